// ----- src/brfew_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brfew_pkg
// Shared types and codes of the byte ring FIFO with endian word access.
// ----------------------------------------------------------------------------
package brfew_pkg;

  localparam int LANES    = 8;
  localparam int FILL_W   = 11;
  localparam int DROP_W   = 11;
  localparam int WORD_W   = 64;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_DISCARD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  // what the result stage needs to know about an item in flight
  typedef struct packed {
    status_t           status;
    logic [FILL_W-1:0] fill;
    logic              word_en;    // pop or peek that succeeded
    logic              big;
    logic [1:0]        size_code;
    logic [2:0]        off;        // bank of the oldest byte
  } item_info_t;

endpackage

`default_nettype wire

// ----- src/brfew_bank.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brfew_bank
// One byte-wide memory bank: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brfew_bank #(
  parameter int RW = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [RW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [RW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [1 << RW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/brfew_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brfew_ctrl
// Pointer and count state, command checks, and bank addressing for the
// byte lanes of a push and the read of a pop or peek.
// ----------------------------------------------------------------------------
module brfew_ctrl
  import brfew_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int PW    = $clog2(DEPTH),
  parameter int RW    = PW - 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_fire,
  input  wire logic [1:0]              cmd,
  input  wire logic [1:0]              size_code,
  input  wire logic                    big_endian,
  input  wire logic [WORD_W-1:0]       word_in,
  input  wire logic [DROP_W-1:0]       drop_count,
  output logic      [LANES-1:0]        bank_we,
  output logic      [LANES-1:0][RW-1:0] bank_waddr,
  output logic      [LANES-1:0][7:0]   bank_wdata,
  output logic      [LANES-1:0][RW-1:0] bank_raddr,
  output item_info_t                   info
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > FILL_W) ? CW : FILL_W;
  localparam logic [XW:0] DEPTH_X = (XW + 1)'(DEPTH);

  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [3:0]    nb;
  logic [XW-1:0] cnt_x, nb_x, drop_x, cnt_w;
  logic          ovf, unf_word, unf_drop, push_ok;
  logic [2:0]    roff, woff;
  status_t       status;
  logic          word_en;

  always_comb begin
    nb       = 4'd1 << size_code;
    cnt_x    = XW'(cnt_r);
    nb_x     = XW'(nb);
    drop_x   = XW'(drop_count);
    ovf      = ({1'b0, cnt_x} + {1'b0, nb_x}) > DEPTH_X;
    unf_word = cnt_x < nb_x;
    unf_drop = drop_x > cnt_x;

    status  = STAT_OK;
    word_en = 1'b0;
    push_ok = 1'b0;
    cnt_w   = cnt_x;
    rp_nxt  = rp_r;
    wp_nxt  = wp_r;
    unique case (cmd_t'(cmd))
      CMD_PUSH: begin
        if (ovf) begin
          status = STAT_OVERFLOW;
        end else begin
          push_ok = 1'b1;
          cnt_w   = cnt_x + nb_x;
          wp_nxt  = wp_r + PW'(nb);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (unf_word) begin
          status = STAT_UNDERFLOW;
        end else begin
          word_en = 1'b1;
          if (cmd_t'(cmd) == CMD_POP) begin
            cnt_w  = cnt_x - nb_x;
            rp_nxt = rp_r + PW'(nb);
          end
        end
      end
      CMD_DISCARD: begin
        if (unf_drop) begin
          status = STAT_UNDERFLOW;
        end else begin
          cnt_w  = cnt_x - drop_x;
          rp_nxt = rp_r + drop_x[PW-1:0];
        end
      end
      default: begin
        status = STAT_OK;
      end
    endcase
    cnt_nxt = cnt_w[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      cnt_r <= '0;
    end else if (in_fire) begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // byte at address a lives in bank a[2:0], row a[PW-1:3]; a bank below
  // the start offset holds the byte of the following row
  always_comb begin
    logic [2:0] idx;
    logic [2:0] sel;
    roff = rp_r[2:0];
    woff = wp_r[2:0];
    for (int b = 0; b < LANES; b++) begin
      bank_raddr[b] = rp_r[PW-1:3] + RW'(3'(b) < roff);
      bank_waddr[b] = wp_r[PW-1:3] + RW'(3'(b) < woff);
      idx           = 3'(b) - woff;
      sel           = big_endian ? 3'(nb - 4'd1 - {1'b0, idx}) : idx;
      bank_wdata[b] = word_in[8*sel +: 8];
      bank_we[b]    = in_fire && push_ok && ({1'b0, idx} < nb);
    end
  end

  always_comb begin
    info.status    = status;
    info.fill      = cnt_w[FILL_W-1:0];
    info.word_en   = word_en;
    info.big       = big_endian;
    info.size_code = size_code;
    info.off       = roff;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("byte count above depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r == PW'({1'b0, rp_r} + cnt_r))
    else $error("write pointer does not match read pointer plus count");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && status != STAT_OK) |=> $stable(cnt_r) && $stable(rp_r) && $stable(wp_r))
    else $error("refused command changed state");
`endif

endmodule

`default_nettype wire

// ----- src/brfew_asm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brfew_asm
// Result stage: holds the item info beside the bank read data, assembles
// the word in the requested byte order and drives the output register.
// ----------------------------------------------------------------------------
module brfew_asm
  import brfew_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  input  item_info_t                 info,
  input  wire logic [LANES-1:0][7:0] bank_rdata,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [WORD_W-1:0]     out_word_out,
  output logic      [1:0]            out_status,
  output logic      [FILL_W-1:0]     out_fill_level
);

  logic              s1_valid_r, s1_valid_nxt;
  item_info_t        s1_info_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [1:0]        status_r;
  logic [FILL_W-1:0] fill_r;
  logic              s1_adv;

  // bank read data only changes on an accepted item, so s1 may stall
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || !out_valid_r || out_ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_comb begin
    logic [3:0] nb;
    logic [2:0] pos;
    logic [7:0] byte_i;
    nb       = 4'd1 << s1_info_r.size_code;
    word_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      byte_i = bank_rdata[3'(s1_info_r.off + 3'(i))];
      pos    = s1_info_r.big ? 3'(nb - 4'd1 - 4'(i)) : 3'(i);
      if (s1_info_r.word_en && (4'(i) < nb)) begin
        word_nxt[8*pos +: 8] = byte_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_info_r <= info;
    end
    if (s1_adv) begin
      word_r   <= word_nxt;
      status_r <= s1_info_r.status;
      fill_r   <= s1_info_r.fill;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_out   = word_r;
  assign out_status     = status_r;
  assign out_fill_level = fill_r;

`ifndef SYNTH
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != STAT_OK) |-> word_r == '0)
    else $error("refused item carries a nonzero word");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_fire)
    else $error("item accepted while result stage is stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> status_r != 2'd3)
    else $error("undefined status code");
`endif

endmodule

`default_nettype wire

// ----- src/byte_ring_fifo_endian_words_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_endian_words_top
// Byte FIFO in a ring of DEPTH bytes with push, pop, peek and discard of
// 1, 2, 4 or 8 byte words in either byte order.
// ----------------------------------------------------------------------------
// One command per item, one result per item, one item per cycle sustained
// while out_ready is high. The ring is split into eight byte-wide banks
// (byte a in bank a mod 8), so any word of up to eight bytes is one write
// or one read per bank. The bank read and the item info are registered
// when the item is accepted; the word is then assembled into the output
// register when the result stage advances, which waits on out_ready.
// DEPTH must be a power of two. Store contents are undefined after reset;
// only pushed bytes are ever returned. A refused command leaves the state
// unchanged and returns a zero word with an overflow or underflow status.
// ----------------------------------------------------------------------------
module byte_ring_fifo_endian_words_top
  import brfew_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [1:0]        in_size_code,
  input  wire logic              in_big_endian,
  input  wire logic [WORD_W-1:0] in_word_in,
  input  wire logic [DROP_W-1:0] in_drop_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [WORD_W-1:0] out_word_out,
  output logic      [1:0]        out_status,
  output logic      [FILL_W-1:0] out_fill_level
);

  localparam int PW = $clog2(DEPTH);
  localparam int RW = PW - 3;

  logic                    in_fire;
  logic [LANES-1:0]        bank_we;
  logic [LANES-1:0][RW-1:0] bank_waddr;
  logic [LANES-1:0][7:0]   bank_wdata;
  logic [LANES-1:0][RW-1:0] bank_raddr;
  logic [LANES-1:0][7:0]   bank_rdata;
  item_info_t              info;

  assign in_fire = in_valid && in_ready;

  brfew_ctrl #(
    .DEPTH (DEPTH),
    .PW    (PW),
    .RW    (RW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .cmd        (in_cmd),
    .size_code  (in_size_code),
    .big_endian (in_big_endian),
    .word_in    (in_word_in),
    .drop_count (in_drop_count),
    .bank_we    (bank_we),
    .bank_waddr (bank_waddr),
    .bank_wdata (bank_wdata),
    .bank_raddr (bank_raddr),
    .info       (info)
  );

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    brfew_bank #(
      .RW (RW)
    ) u_bank (
      .clk     (clk),
      .we      (bank_we[b]),
      .waddr   (bank_waddr[b]),
      .wdata   (bank_wdata[b]),
      .re      (in_fire),
      .raddr   (bank_raddr[b]),
      .rdata_r (bank_rdata[b])
    );
  end

  brfew_asm u_asm (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .info           (info),
    .bank_rdata     (bank_rdata),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word_out   (out_word_out),
    .out_status     (out_status),
    .out_fill_level (out_fill_level)
  );

endmodule

`default_nettype wire
